// File: src/euclid_gcd_unit_top_assert.svh
// Assertion macros used by the GCD unit's core, egcd_core.sv.
`ifndef EUCLID_GCD_UNIT_TOP_ASSERT_SVH
`define EUCLID_GCD_UNIT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EGCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("egcd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EGCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("egcd: next-cycle check failed");

`endif

// File: src/egcd_pkg.sv
// Package with widths and control types of the GCD unit.
`default_nettype none

package egcd_pkg;

  localparam int OPERAND_BITS = 31;
  // The shift count reaches at most OPERAND_BITS - 1.
  localparam int SHIFT_BITS   = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [SHIFT_BITS-1:0]   shift_t;

  typedef struct packed {
    logic start;  // load a new operand pair
    logic take;   // result is moved into the output register
  } egcd_ctrl_t;

  typedef struct packed {
    logic idle;   // core can load a new pair
    logic done;   // core holds a finished result
  } egcd_stat_t;

endpackage

`default_nettype wire

// File: src/egcd_in_if.sv
// Input channel: operand pair with valid/ready handshake.
`default_nettype none

interface egcd_in_if;
  logic               valid;
  logic               ready;
  egcd_pkg::operand_t first_value;
  egcd_pkg::operand_t second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

`default_nettype wire

// File: src/egcd_out_if.sv
// Output channel: gcd result with valid/ready handshake.
`default_nettype none

interface egcd_out_if;
  logic               valid;
  logic               ready;
  egcd_pkg::operand_t divisor;
  logic               both_zero;

  modport source (output valid, output divisor, output both_zero, input ready);
  modport sink   (input valid, input divisor, input both_zero, output ready);
endinterface

`default_nettype wire

// File: src/euclid_gcd_unit_top.sv
// Top level of the GCD unit: handshake, core and output register.
//
//   Channel  Dir  Payload                       Handshake
//   in_i     in   first_value, second_value     valid/ready
//   out_o    out  divisor, both_zero            valid/ready
//
// An operand pair is loaded into the core, which then runs the binary GCD
// loop one step per cycle on the shared subtract/compare unit; a pair with a
// zero operand skips the loop. The result then moves into the output register.
// Reset is asynchronous and active low; it clears the sequencer and the
// output valid. The output register frees the core: the next pair is taken
// while a result waits, and the core stalls only on a full, unread register.
`default_nettype none

module euclid_gcd_unit_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  egcd_in_if.sink     in_i,
  egcd_out_if.source  out_o
);

  egcd_pkg::egcd_ctrl_t ctrl;
  egcd_pkg::egcd_stat_t stat;
  egcd_pkg::operand_t   core_divisor;
  logic                 core_both_zero;

  logic                 out_valid_q, out_valid_d;
  egcd_pkg::operand_t   divisor_q;
  logic                 both_zero_q;

  assign in_i.ready = stat.idle;
  assign ctrl.start = in_i.valid && stat.idle;
  assign ctrl.take  = stat.done && (!out_valid_q || out_o.ready);

  egcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .first_i     (in_i.first_value),
    .second_i    (in_i.second_value),
    .stat_o      (stat),
    .divisor_o   (core_divisor),
    .both_zero_o (core_both_zero)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      divisor_q   <= core_divisor;
      both_zero_q <= core_both_zero;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.divisor   = divisor_q;
  assign out_o.both_zero = both_zero_q;

endmodule

`default_nettype wire

// File: src/egcd_core.sv
// Binary GCD sequencer with one shared subtract and compare unit.
`default_nettype none
`include "euclid_gcd_unit_top_assert.svh"

module egcd_core (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  egcd_pkg::egcd_ctrl_t    ctrl_i,
  input  egcd_pkg::operand_t      first_i,
  input  egcd_pkg::operand_t      second_i,
  output egcd_pkg::egcd_stat_t    stat_o,
  output egcd_pkg::operand_t      divisor_o,
  output logic                    both_zero_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  egcd_pkg::operand_t a_q, a_d;
  egcd_pkg::operand_t b_q, b_d;
  egcd_pkg::shift_t   k_q, k_d;
  logic               zero_q, zero_d;

  // Shared unit: both differences, the borrow of a - b as the less-than compare, and an equality compare.
  logic [egcd_pkg::OPERAND_BITS:0]   diff_ab;
  logic [egcd_pkg::OPERAND_BITS-1:0] diff_ba;
  logic                              a_lt_b;
  logic                              a_eq_b;

  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = b_q - a_q;
  assign a_lt_b  = diff_ab[egcd_pkg::OPERAND_BITS];
  assign a_eq_b  = (a_q == b_q);

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    zero_d  = zero_q;
    case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          a_d    = first_i;
          b_d    = second_i;
          k_d    = '0;
          zero_d = (first_i == '0) && (second_i == '0);
          if ((first_i == '0) || (second_i == '0)) begin
            // With a zero operand the other one is the answer.
            a_d     = first_i | second_i;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + egcd_pkg::SHIFT_BITS'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_eq_b) begin
          // Restore the common power of two stripped at the start.
          a_d     = a_q << k_q;
          state_d = ST_DONE;
        end else if (a_lt_b) begin
          b_d = diff_ba >> 1;
        end else begin
          a_d = diff_ab[egcd_pkg::OPERAND_BITS-1:0] >> 1;
        end
      end
      ST_DONE: begin
        if (ctrl_i.take) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    k_q    <= k_d;
    zero_q <= zero_d;
  end

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign divisor_o   = zero_q ? '0 : a_q;
  assign both_zero_o = zero_q;

  `EGCD_ASSERT_NOW(run_nonzero_a, clk_i, rst_ni, state_q == ST_RUN,
                   (a_q != '0) && (b_q != '0))
  `EGCD_ASSERT_NOW(run_shift_bound, clk_i, rst_ni, state_q == ST_RUN,
                   {1'b0, k_q} < (egcd_pkg::SHIFT_BITS+1)'(egcd_pkg::OPERAND_BITS))
  `EGCD_ASSERT_NEXT(done_to_idle, clk_i, rst_ni, (state_q == ST_DONE) && ctrl_i.take,
                    state_q == ST_IDLE)
  `EGCD_ASSERT_NEXT(zero_start_done, clk_i, rst_ni,
                    (state_q == ST_IDLE) && ctrl_i.start &&
                    ((first_i == '0) || (second_i == '0)),
                    state_q == ST_DONE)

endmodule

`default_nettype wire

// File: test/euclid_gcd_unit_top_tb.sv
// Self-checking testbench for the GCD unit: directed and random operand pairs, random stalls on both sides.
`timescale 1ns / 1ps

module euclid_gcd_unit_top_tb;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 1230;
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct packed {
    egcd_pkg::operand_t divisor;
    logic               both_zero;
  } gcd_result_t;

  // Holds the predicted results of accepted operand pairs, oldest first.
  class gcd_ledger;
    gcd_result_t pending_q[$];
    int unsigned mismatches;

    function gcd_result_t predict_gcd(egcd_pkg::operand_t a, egcd_pkg::operand_t b);
      gcd_result_t        res;
      egcd_pkg::operand_t x;
      egcd_pkg::operand_t y;
      egcd_pkg::operand_t r;
      x = a;
      y = b;
      res.both_zero = (a == '0) && (b == '0);
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor = res.both_zero ? '0 : x;
      return res;
    endfunction

    function void note_pair(egcd_pkg::operand_t a, egcd_pkg::operand_t b);
      pending_q.push_back(predict_gcd(a, b));
    endfunction

    function void check_result(egcd_pkg::operand_t divisor, logic both_zero);
      gcd_result_t want;
      if (pending_q.size() == 0) begin
        $error("result with no pending pair: divisor %0d, both_zero %0b", divisor, both_zero);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (divisor !== want.divisor) begin
        $error("divisor: expected %0d, got %0d", want.divisor, divisor);
        mismatches++;
      end
      if (both_zero !== want.both_zero) begin
        $error("both_zero: expected %0b, got %0b", want.both_zero, both_zero);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  egcd_in_if  pair_ch ();
  egcd_out_if gcd_ch ();

  euclid_gcd_unit_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pair_ch.sink),
    .out_o  (gcd_ch.source)
  );

  gcd_ledger   ledger = new();
  int unsigned pairs_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    rst_n                = 1'b0;
    pair_ch.valid        = 1'b0;
    pair_ch.first_value  = '0;
    pair_ch.second_value = '0;
    gcd_ch.ready         = 1'b0;
  end

  // Presents one pair and returns at the edge where the transaction happens.
  // Every other block of 64 pairs is sent back to back.
  task automatic send_pair(egcd_pkg::operand_t a, egcd_pkg::operand_t b);
    int unsigned gap;
    gap = pairs_sent[6] ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pair_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_ch.valid        <= 1'b1;
    pair_ch.first_value  <= a;
    pair_ch.second_value <= b;
    do @(posedge clk); while (!pair_ch.ready);
    ledger.note_pair(a, b);
    pairs_sent++;
  endtask

  task automatic drain_results();
    pair_ch.valid <= 1'b0;
    while (ledger.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic egcd_pkg::operand_t any_operand();
    return egcd_pkg::operand_t'($urandom);
  endfunction

  task automatic send_random_pair();
    egcd_pkg::operand_t a;
    egcd_pkg::operand_t b;
    int unsigned        g;
    int unsigned        k;
    case ($urandom_range(0, 9))
      0: begin
        a = any_operand();
        b = any_operand();
      end
      1, 2, 3: begin
        // Shared factor so that the divisor is usually well above one.
        g = $urandom_range(1, 65535);
        a = egcd_pkg::operand_t'(g * $urandom_range(0, 32'h7fff_ffff / g));
        b = egcd_pkg::operand_t'(g * $urandom_range(0, 32'h7fff_ffff / g));
      end
      4: begin
        k = $urandom_range(0, 30);
        a = any_operand() << k;
        b = any_operand() << $urandom_range(0, k);
      end
      5: begin
        a = egcd_pkg::operand_t'($urandom_range(0, 15));
        b = egcd_pkg::operand_t'($urandom_range(0, 15));
      end
      6: begin
        a = $urandom_range(0, 1) ? any_operand() : '0;
        b = (a == '0) ? any_operand() >> $urandom_range(0, 30) : '0;
      end
      7: begin
        a = any_operand() >> $urandom_range(0, 30);
        b = a;
      end
      default: begin
        a = any_operand() >> $urandom_range(0, 30);
        b = any_operand() >> $urandom_range(0, 30);
      end
    endcase
    send_pair(a, b);
  endtask

  // Result side: random stalls, with every other block of 32 results taken at once.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = results_seen[5] ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        gcd_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      gcd_ch.ready <= 1'b1;
      do @(posedge clk); while (!gcd_ch.valid);
      ledger.check_result(gcd_ch.divisor, gcd_ch.both_zero);
      results_seen++;
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pair_ch.valid && pair_ch.ready) || (gcd_ch.valid && gcd_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    idle_cycles  = 0;
    pairs_sent   = 0;
    results_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero operands, extremes, equal values and the slowest Euclid chain.
    send_pair(31'd0, 31'd0);
    send_pair(31'd12345, 31'd0);
    send_pair(31'd0, 31'd67890);
    send_pair(31'h7fff_ffff, 31'd0);
    send_pair(31'd0, 31'h7fff_ffff);
    send_pair(31'h7fff_ffff, 31'h7fff_ffff);
    send_pair(31'h7fff_ffff, 31'd1);
    send_pair(31'd1, 31'h7fff_ffff);
    send_pair(31'd1, 31'd1);
    send_pair(31'h7fff_ffff, 31'h7fff_fffe);
    send_pair(31'd1134903170, 31'd1836311903);
    send_pair(31'd1836311903, 31'd1134903170);
    send_pair(31'h4000_0000, 31'h6000_0000);
    send_pair(31'h4000_0000, 31'd1);
    send_pair(31'h2aaa_aaaa, 31'h5555_5555);
    send_pair(31'h5555_5555, 31'h2aaa_aaaa);
    send_pair(31'd12, 31'd18);
    send_pair(31'd2147483629, 31'd2147483647);
    send_pair(31'd1073741824, 31'd1073741824);
    send_pair(31'd6, 31'd4);
    drain_results();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      send_random_pair();
      if (i % 300 == 299) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/egcd_pkg.sv
src/egcd_in_if.sv
src/egcd_out_if.sv
src/egcd_core.sv
src/euclid_gcd_unit_top.sv
test/euclid_gcd_unit_top_tb.sv
